/* rtl/atb_pkg.sv */
// Shared widths, command and status types, and divider operand codes for the alias table builder.
`timescale 1ns / 1ps

package atb_pkg;

	localparam int WW     = 16;  // weight width
	localparam int SW     = 22;  // scaled weight, total and fraction width
	localparam int IW     = 6;   // entry and alias index width on the output word
	localparam int IN_TW  = 16;  // input tdata width
	localparam int OUT_TW = 56;  // output tdata width

	// Divider operand selection.
	localparam logic [1:0] DSEL_GCD = 2'd0;  // gcd_a % gcd_b
	localparam logic [1:0] DSEL_NUM = 2'd1;  // numerator / gcd
	localparam logic [1:0] DSEL_DEN = 2'd2;  // total / gcd

	typedef struct packed {
		logic       load;
		logic       scale;
		logic       pop;
		logic       take_tops;
		logic       take_sc;
		logic       upd;
		logic       push_l;
		logic       div_start;
		logic [1:0] div_sel;
		logic       gcd_step;
		logic       take_p;
		logic       take_d;
		logic       wr_ent;
		logic       lpop_s;
		logic       lpop_l;
		logic       wr_one;
		logic       emit_clr;
		logic       emit_ld;
	} cmd_t;

	typedef struct packed {
		logic last_acc;
		logic scale_done;
		logic pair_ok;
		logic s_ne;
		logic l_ne;
		logic num_zero;
		logic b_zero;
		logic div_done;
		logic out_free;
		logic last_idx;
	} stat_t;

endpackage

/* rtl/alias_table_builder_core.sv */
// Weights are taken one word per cycle; the word flagged last starts the build of N entries.
// Build: the weights are scaled, then each pairing runs (a zero numerator skips the gcd),
// with the Euclid steps and the two reducing divisions in the shared divider, and then
// each leftover entry is written. Emission: each entry is read, then loaded into the output
// register once it is free; new weights are accepted as soon as the final entry sits there.
// Reset clears the controller, counters and output valid at once; memories are not cleared.
`timescale 1ns / 1ps

module alias_table_builder_core import atb_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,   // [15:0] weight
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,   // [5:0] entry_index, [27:6] prob_num,
	                                     // [49:28] prob_den, [55:50] alias_index
	output logic              m_tuser,   // [0] has_alias
	output logic              m_tlast
);

	cmd_t  cmd;
	stat_t stat;

	atb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	atb_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	assign s_tready = cmd.load;

`ifndef SYNTH
	a_build_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still ready after the final weight word");

	a_pair_needs_both: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> stat.pair_ok)
		else $error("pairing pop with an empty stack");

	a_reload_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld && stat.last_idx |=> s_tready)
		else $error("input not ready after the final entry was loaded");
`endif

endmodule

/* rtl/atb_div.sv */
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
`timescale 1ns / 1ps

module atb_div import atb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [SW-1:0] dividend,
	input  logic [SW-1:0] divisor,
	output logic          done,
	output logic [SW-1:0] quo,
	output logic [SW-1:0] rem
);

	localparam int CNTW = $clog2(SW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [SW-1:0]   rem_q;
	logic [SW-1:0]   quo_q;
	logic [SW-1:0]   dsr_q;
	logic [SW:0]     sh;
	logic [SW:0]     diff;
	logic            ge;

	always_comb begin
		sh   = {rem_q, quo_q[SW-1]};
		ge   = sh >= {1'b0, dsr_q};
		diff = sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SW-1:0] : sh[SW-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

/* rtl/atb_datapath.sv */
// Datapath: weight, scaled weight, stack and entry memories, gcd registers and output register.
`timescale 1ns / 1ps

module atb_datapath import atb_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              s_tvalid,
	input  logic [IN_TW-1:0]  s_tdata,
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	logic [WW-1:0] wmem [MAX_ENTRIES];
	logic [SW-1:0] smem [MAX_ENTRIES];
	logic [AW-1:0] sstk [MAX_ENTRIES];
	logic [AW-1:0] lstk [MAX_ENTRIES];
	logic [SW-1:0] pmem [MAX_ENTRIES];
	logic [SW-1:0] dmem [MAX_ENTRIES];
	logic [AW:0]   amem [MAX_ENTRIES];

	logic [CW-1:0] cnt_q, n_q, idx_q, sdep_q, ldep_q;
	logic [SW-1:0] sum_q, tot_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;
	logic [WW-1:0] w_rd_q;
	logic [SW-1:0] sma_rd_q, smb_rd_q;
	logic [AW-1:0] sstk_rd_q, lstk_rd_q;
	logic [SW-1:0] p_rd_q, d_rd_q;
	logic [AW:0]   a_rd_q;
	logic [AW-1:0] s_q, l_q;
	logic [SW-1:0] num_q, lsc_q, nl_q, ga_q, gb_q, p_q, d_q;
	logic          sel_q;

	logic              out_v_q;
	logic [IW-1:0]     out_idx_q, out_al_q;
	logic [SW-1:0]     out_p_q, out_d_q;
	logic              out_ha_q, out_last_q;

	logic              accept, room, issue, last_acc;
	logic [WW-1:0]     w_in;
	logic [SW-1:0]     sum_add;
	logic [WW+CW-1:0]  prod_full;
	logic [SW-1:0]     prod;
	logic              prod_small, nl_small;
	logic [SW:0]       nl_w;
	logic              s_push, l_push;
	logic [AW-1:0]     push_val;
	logic [AW-1:0]     s_ra, l_ra;
	logic              sm_we;
	logic [AW-1:0]     sm_wa;
	logic [SW-1:0]     sm_wd;
	logic              en_we;
	logic [AW-1:0]     en_wa;
	logic [SW-1:0]     en_p, en_d;
	logic [AW:0]       en_a;
	logic [SW-1:0]     div_a, div_b, div_quo, div_rem;
	logic              div_done;
	logic              last_idx;

	always_comb begin
		accept     = cmd.load && s_tvalid;
		last_acc   = accept && s_tlast;
		room       = cnt_q < MAX_CNT;
		w_in       = s_tdata[WW-1:0];
		sum_add    = sum_q + SW'(w_in);
		issue      = cmd.scale && (idx_q < n_q);
		prod_full  = w_rd_q * n_q;
		prod       = SW'(prod_full);
		prod_small = prod < tot_q;
		// The large entry gives up (total - num); the result never goes negative.
		nl_w       = {1'b0, lsc_q} + {1'b0, num_q} - {1'b0, tot_q};
		nl_small   = nl_q < tot_q;
		s_push     = (v_s1 && prod_small) || (cmd.push_l && nl_small);
		l_push     = (v_s1 && !prod_small) || (cmd.push_l && !nl_small);
		push_val   = v_s1 ? idx_s1 : l_q;
		s_ra       = AW'(sdep_q - CW'(1));
		l_ra       = AW'(ldep_q - CW'(1));
		sm_we      = v_s1 || cmd.upd;
		sm_wa      = v_s1 ? idx_s1 : l_q;
		sm_wd      = v_s1 ? prod : nl_w[SW-1:0];
		en_we      = cmd.wr_ent || cmd.wr_one;
		if (cmd.wr_ent) begin
			en_wa = s_q;
			en_p  = p_q;
			en_d  = d_q;
			en_a  = {1'b1, l_q};
		end else begin
			en_wa = sel_q ? lstk_rd_q : sstk_rd_q;
			en_p  = SW'(1);
			en_d  = SW'(1);
			en_a  = '0;
		end
		unique case (cmd.div_sel)
			DSEL_NUM: begin
				div_a = num_q;
				div_b = ga_q;
			end
			DSEL_DEN: begin
				div_a = tot_q;
				div_b = ga_q;
			end
			default: begin
				div_a = ga_q;
				div_b = gb_q;
			end
		endcase
		last_idx = idx_q == (n_q - CW'(1));
	end

	atb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Load counters, depths, scan index, scale valid, leftover select and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			n_q     <= '0;
			tot_q   <= '0;
			idx_q   <= '0;
			sdep_q  <= '0;
			ldep_q  <= '0;
			v_s1    <= 1'b0;
			sel_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (last_acc) begin
				n_q    <= room ? cnt_q + CW'(1) : cnt_q;
				tot_q  <= room ? sum_add : sum_q;
				cnt_q  <= '0;
				sum_q  <= '0;
				idx_q  <= '0;
				sdep_q <= '0;
				ldep_q <= '0;
			end else begin
				if (accept && room) begin
					cnt_q <= cnt_q + CW'(1);
					sum_q <= sum_add;
				end
				priority if (issue || cmd.emit_ld) begin
					idx_q <= idx_q + CW'(1);
				end else if (cmd.emit_clr) begin
					idx_q <= '0;
				end
				priority if (s_push) begin
					sdep_q <= sdep_q + CW'(1);
				end else if (cmd.pop || cmd.lpop_s) begin
					sdep_q <= sdep_q - CW'(1);
				end
				priority if (l_push) begin
					ldep_q <= ldep_q + CW'(1);
				end else if (cmd.pop || cmd.lpop_l) begin
					ldep_q <= ldep_q - CW'(1);
				end
			end
			if (cmd.lpop_s) begin
				sel_q <= 1'b0;
			end else if (cmd.lpop_l) begin
				sel_q <= 1'b1;
			end
			if (cmd.emit_ld) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && room) begin
			wmem[cnt_q[AW-1:0]] <= w_in;
		end
		w_rd_q <= wmem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sm_we) begin
			smem[sm_wa] <= sm_wd;
		end
		sma_rd_q <= smem[sstk_rd_q];
		smb_rd_q <= smem[lstk_rd_q];
	end

	always_ff @(posedge clk) begin
		if (s_push) begin
			sstk[sdep_q[AW-1:0]] <= push_val;
		end
		sstk_rd_q <= sstk[s_ra];
	end

	always_ff @(posedge clk) begin
		if (l_push) begin
			lstk[ldep_q[AW-1:0]] <= push_val;
		end
		lstk_rd_q <= lstk[l_ra];
	end

	always_ff @(posedge clk) begin
		if (en_we) begin
			pmem[en_wa] <= en_p;
		end
		p_rd_q <= pmem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (en_we) begin
			dmem[en_wa] <= en_d;
		end
		d_rd_q <= dmem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (en_we) begin
			amem[en_wa] <= en_a;
		end
		a_rd_q <= amem[idx_q[AW-1:0]];
	end

	// Pairing and gcd working registers.
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.take_tops) begin
			s_q <= sstk_rd_q;
			l_q <= lstk_rd_q;
		end
		if (cmd.take_sc) begin
			num_q <= sma_rd_q;
			lsc_q <= smb_rd_q;
		end
		if (cmd.upd) begin
			nl_q <= nl_w[SW-1:0];
		end
		if (cmd.push_l) begin
			ga_q <= num_q;
			gb_q <= tot_q;
			p_q  <= '0;
			d_q  <= SW'(1);
		end else if (cmd.gcd_step) begin
			ga_q <= gb_q;
			gb_q <= div_rem;
		end
		if (cmd.take_p) begin
			p_q <= div_quo;
		end
		if (cmd.take_d) begin
			d_q <= div_quo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_idx_q  <= IW'(idx_q);
			out_p_q    <= p_rd_q;
			out_d_q    <= d_rd_q;
			out_al_q   <= a_rd_q[AW] ? IW'(a_rd_q[AW-1:0]) : '0;
			out_ha_q   <= a_rd_q[AW];
			out_last_q <= last_idx;
		end
	end

	always_comb begin
		stat.last_acc   = last_acc;
		stat.scale_done = (idx_q == n_q) && !v_s1;
		stat.pair_ok    = (sdep_q != '0) && (ldep_q != '0);
		stat.s_ne       = sdep_q != '0;
		stat.l_ne       = ldep_q != '0;
		stat.num_zero   = num_q == '0;
		stat.b_zero     = gb_q == '0;
		stat.div_done   = div_done;
		stat.out_free   = !out_v_q || m_tready;
		stat.last_idx   = last_idx;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_al_q, out_d_q, out_p_q, out_idx_q};
	assign m_tuser  = out_ha_q;
	assign m_tlast  = out_last_q;

endmodule

/* rtl/atb_ctrl.sv */
// Controller state machine that sequences loading, scaling, pairing, gcd reduction, leftover entries and emission.
`timescale 1ns / 1ps

module atb_ctrl import atb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_SCALE = 5'd1;
	localparam logic [4:0] S_POP   = 5'd2;
	localparam logic [4:0] S_TOPS  = 5'd3;
	localparam logic [4:0] S_SC    = 5'd4;
	localparam logic [4:0] S_UPD   = 5'd5;
	localparam logic [4:0] S_PUSH  = 5'd6;
	localparam logic [4:0] S_GCD   = 5'd7;
	localparam logic [4:0] S_GWAIT = 5'd8;
	localparam logic [4:0] S_DIVN  = 5'd9;
	localparam logic [4:0] S_DNW   = 5'd10;
	localparam logic [4:0] S_DIVD  = 5'd11;
	localparam logic [4:0] S_DDW   = 5'd12;
	localparam logic [4:0] S_WRENT = 5'd13;
	localparam logic [4:0] S_LPOP  = 5'd14;
	localparam logic [4:0] S_LWR   = 5'd15;
	localparam logic [4:0] S_ERD   = 5'd16;
	localparam logic [4:0] S_ELD   = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_comb begin
		cmd         = '0;
		cmd.div_sel = DSEL_GCD;
		state_d     = state_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.load = 1'b1;
				if (stat.last_acc) begin
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				if (stat.scale_done) begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (stat.pair_ok) begin
					cmd.pop = 1'b1;
					state_d = S_TOPS;
				end else begin
					state_d = S_LPOP;
				end
			end
			S_TOPS: begin
				cmd.take_tops = 1'b1;
				state_d       = S_SC;
			end
			S_SC: begin
				cmd.take_sc = 1'b1;
				state_d     = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				cmd.push_l = 1'b1;
				// A zero numerator is reported as 0/1 without a gcd.
				state_d = stat.num_zero ? S_WRENT : S_GCD;
			end
			S_GCD: begin
				if (stat.b_zero) begin
					state_d = S_DIVN;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_GWAIT;
				end
			end
			S_GWAIT: begin
				if (stat.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d      = S_GCD;
				end
			end
			S_DIVN: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_NUM;
				state_d       = S_DNW;
			end
			S_DNW: begin
				if (stat.div_done) begin
					cmd.take_p = 1'b1;
					state_d    = S_DIVD;
				end
			end
			S_DIVD: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_DEN;
				state_d       = S_DDW;
			end
			S_DDW: begin
				if (stat.div_done) begin
					cmd.take_d = 1'b1;
					state_d    = S_WRENT;
				end
			end
			S_WRENT: begin
				cmd.wr_ent = 1'b1;
				state_d    = S_POP;
			end
			S_LPOP: begin
				priority if (stat.s_ne) begin
					cmd.lpop_s = 1'b1;
					state_d    = S_LWR;
				end else if (stat.l_ne) begin
					cmd.lpop_l = 1'b1;
					state_d    = S_LWR;
				end else begin
					cmd.emit_clr = 1'b1;
					state_d      = S_ERD;
				end
			end
			S_LWR: begin
				cmd.wr_one = 1'b1;
				state_d    = S_LPOP;
			end
			S_ERD: begin
				state_d = S_ELD;
			end
			S_ELD: begin
				if (stat.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d     = stat.last_idx ? S_LOAD : S_ERD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
